@@ rtl/urbf_pkg.sv @@
// Shared constants, codes and control structures of the UART ring buffer block.
`default_nettype none

package urbf_pkg;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);

    localparam int SIZE_W   = 9;
    localparam int HEAD_W   = 8;
    localparam int FILL_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;
    localparam int CFG_IW   = 3;

    localparam logic [OP_W-1:0] OP_LINE_IN  = 3'd0;
    localparam logic [OP_W-1:0] OP_HOST_RD  = 3'd1;
    localparam logic [OP_W-1:0] OP_HOST_WR  = 3'd2;
    localparam logic [OP_W-1:0] OP_TX_READY = 3'd3;
    localparam logic [OP_W-1:0] OP_TX_DONE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RX_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_TX_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RX_DROP  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TX_EMPTY = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_RX_SIZE     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TX_SIZE     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RX_HEADROOM = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RX_FLOW_EN  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HALF_DUPLEX = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef struct packed {
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    // Clamps a configured ring size into the range one to the ring depth.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] depth);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > depth) begin
            r = depth;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/urbf_in_if.sv @@
// Input channel carrying one event item.
`default_nettype none

interface urbf_in_if;
    logic                              valid;
    logic                              ready;
    logic [urbf_pkg::OP_W-1:0]         operation;
    logic [urbf_pkg::BYTE_W-1:0]       data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/urbf_out_if.sv @@
// Output channel carrying one result item.
`default_nettype none

interface urbf_out_if;
    logic                              valid;
    logic                              ready;
    logic [urbf_pkg::STAT_W-1:0]       status;
    logic [urbf_pkg::BYTE_W-1:0]       read_data;
    logic                              read_valid;
    logic [urbf_pkg::BYTE_W-1:0]       send_data;
    logic                              send_valid;
    logic                              rts_asserted;
    logic                              tx_drive;
    logic                              tx_busy;
    logic [urbf_pkg::FILL_W-1:0]       rx_fill;
    logic [urbf_pkg::FILL_W-1:0]       tx_fill;

    modport source (output valid, output status, output read_data, output read_valid,
                    output send_data, output send_valid, output rts_asserted,
                    output tx_drive, output tx_busy, output rx_fill, output tx_fill,
                    input ready);
    modport sink   (input valid, input status, input read_data, input read_valid,
                    input send_data, input send_valid, input rts_asserted,
                    input tx_drive, input tx_busy, input rx_fill, input tx_fill,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/urbf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/urbf_ctrl.sv @@
// Controller state machine sequencing the execute and result load steps.
`default_nettype none

module urbf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire urbf_pkg::t_stat i_stat,
    output urbf_pkg::t_cmd       o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/urbf_dp.sv @@
// Datapath holding the rings, their pointers and counts, flow control and the result register.
`default_nettype none

module urbf_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [urbf_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [urbf_pkg::SIZE_W-1:0]      i_cfg_data,
    input  wire urbf_pkg::t_cmd                   i_cmd,
    output urbf_pkg::t_stat                       o_stat,
    input  wire logic [urbf_pkg::OP_W-1:0]        i_operation,
    input  wire logic [urbf_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic      [urbf_pkg::STAT_W-1:0]      o_status,
    output logic      [urbf_pkg::BYTE_W-1:0]      o_read_data,
    output logic                                  o_read_valid,
    output logic      [urbf_pkg::BYTE_W-1:0]      o_send_data,
    output logic                                  o_send_valid,
    output logic                                  o_rts_asserted,
    output logic                                  o_tx_drive,
    output logic                                  o_tx_busy,
    output logic      [urbf_pkg::FILL_W-1:0]      o_rx_fill,
    output logic      [urbf_pkg::FILL_W-1:0]      o_tx_fill
);

    localparam logic [urbf_pkg::SIZE_W-1:0] RX_DEPTH_SZ = urbf_pkg::SIZE_W'(urbf_pkg::RX_DEPTH);
    localparam logic [urbf_pkg::SIZE_W-1:0] TX_DEPTH_SZ = urbf_pkg::SIZE_W'(urbf_pkg::TX_DEPTH);

    logic [urbf_pkg::SIZE_W-1:0] r_rx_size, r_tx_size;
    logic [urbf_pkg::HEAD_W-1:0] r_rx_headroom;
    logic                        r_rx_flow_en, r_half_duplex;

    logic [urbf_pkg::RX_AW-1:0]  r_rx_put, r_rx_get, n_rx_put, n_rx_get;
    logic [urbf_pkg::TX_AW-1:0]  r_tx_put, r_tx_get, n_tx_put, n_tx_get;
    logic [urbf_pkg::FILL_W-1:0] r_rx_count, r_tx_count, n_rx_count, n_tx_count;
    logic                        r_rts, r_drive, r_busy, n_rts, n_drive, n_busy;

    logic [urbf_pkg::STAT_W-1:0] r_p_status, n_p_status;
    logic                        r_p_rvalid, r_p_svalid, n_p_rvalid, n_p_svalid;

    logic                        r_o_valid;
    logic [urbf_pkg::STAT_W-1:0] r_o_status;
    logic [urbf_pkg::BYTE_W-1:0] r_o_rdata, r_o_sdata;
    logic                        r_o_rvalid, r_o_svalid, r_o_rts, r_o_drive, r_o_busy;
    logic [urbf_pkg::FILL_W-1:0] r_o_rx_fill, r_o_tx_fill;

    logic [urbf_pkg::SIZE_W-1:0] rs, ts, rx_thr;
    logic [urbf_pkg::SIZE_W-1:0] rx_put_inc, rx_get_inc, tx_put_inc, tx_get_inc;
    logic                        rx_we, tx_we;
    logic [urbf_pkg::BYTE_W-1:0] rx_q, tx_q;

    assign rs = urbf_pkg::eff_size(r_rx_size, RX_DEPTH_SZ);
    assign ts = urbf_pkg::eff_size(r_tx_size, TX_DEPTH_SZ);
    assign rx_thr = (rs > urbf_pkg::SIZE_W'(r_rx_headroom))
                    ? rs - urbf_pkg::SIZE_W'(r_rx_headroom) : '0;

    assign rx_put_inc = urbf_pkg::SIZE_W'(r_rx_put) + urbf_pkg::SIZE_W'(1);
    assign rx_get_inc = urbf_pkg::SIZE_W'(r_rx_get) + urbf_pkg::SIZE_W'(1);
    assign tx_put_inc = urbf_pkg::SIZE_W'(r_tx_put) + urbf_pkg::SIZE_W'(1);
    assign tx_get_inc = urbf_pkg::SIZE_W'(r_tx_get) + urbf_pkg::SIZE_W'(1);

    always_comb begin
        n_rx_put   = r_rx_put;
        n_rx_get   = r_rx_get;
        n_rx_count = r_rx_count;
        n_tx_put   = r_tx_put;
        n_tx_get   = r_tx_get;
        n_tx_count = r_tx_count;
        n_rts      = r_rts;
        n_drive    = r_drive;
        n_busy     = r_busy;
        n_p_status = urbf_pkg::ST_OK;
        n_p_rvalid = 1'b0;
        n_p_svalid = 1'b0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        case (i_operation)
            urbf_pkg::OP_LINE_IN: begin
                if (r_rx_count < rs) begin
                    rx_we      = 1'b1;
                    n_rx_put   = (rx_put_inc >= rs) ? '0 : rx_put_inc[urbf_pkg::RX_AW-1:0];
                    n_rx_count = r_rx_count + urbf_pkg::FILL_W'(1);
                    if (r_rx_flow_en && (n_rx_count > rx_thr)) begin
                        n_rts = 1'b1;
                    end
                end else begin
                    n_p_status = urbf_pkg::ST_RX_DROP;
                end
            end
            urbf_pkg::OP_HOST_RD: begin
                if (r_rx_count == '0) begin
                    n_p_status = urbf_pkg::ST_RX_EMPTY;
                end else begin
                    n_p_rvalid = 1'b1;
                    n_rx_get   = (rx_get_inc >= rs) ? '0 : rx_get_inc[urbf_pkg::RX_AW-1:0];
                    n_rx_count = r_rx_count - urbf_pkg::FILL_W'(1);
                    if (r_rx_flow_en && r_rts && (n_rx_count < (rs >> 1))) begin
                        n_rts = 1'b0;
                    end
                end
            end
            urbf_pkg::OP_HOST_WR: begin
                if (r_tx_count >= ts) begin
                    n_p_status = urbf_pkg::ST_TX_FULL;
                end else begin
                    tx_we      = 1'b1;
                    n_tx_put   = (tx_put_inc >= ts) ? '0 : tx_put_inc[urbf_pkg::TX_AW-1:0];
                    n_tx_count = r_tx_count + urbf_pkg::FILL_W'(1);
                    n_busy     = 1'b1;
                    if (r_half_duplex) begin
                        n_drive = 1'b1;
                    end
                end
            end
            urbf_pkg::OP_TX_READY: begin
                if (r_tx_count == '0) begin
                    n_p_status = urbf_pkg::ST_TX_EMPTY;
                end else begin
                    n_p_svalid = 1'b1;
                    n_tx_get   = (tx_get_inc >= ts) ? '0 : tx_get_inc[urbf_pkg::TX_AW-1:0];
                    n_tx_count = r_tx_count - urbf_pkg::FILL_W'(1);
                end
            end
            urbf_pkg::OP_TX_DONE: begin
                n_busy = 1'b0;
                if (r_half_duplex) begin
                    n_drive = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    urbf_ram #(.WIDTH(urbf_pkg::BYTE_W), .DEPTH(urbf_pkg::RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && rx_we),
        .i_waddr (r_rx_put),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.exec),
        .i_raddr (r_rx_get),
        .o_rdata (rx_q)
    );

    urbf_ram #(.WIDTH(urbf_pkg::BYTE_W), .DEPTH(urbf_pkg::TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && tx_we),
        .i_waddr (r_tx_put),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.exec),
        .i_raddr (r_tx_get),
        .o_rdata (tx_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_size     <= urbf_pkg::SIZE_RESET;
            r_tx_size     <= urbf_pkg::SIZE_RESET;
            r_rx_headroom <= '0;
            r_rx_flow_en  <= 1'b0;
            r_half_duplex <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                urbf_pkg::CFG_RX_SIZE:     r_rx_size     <= i_cfg_data;
                urbf_pkg::CFG_TX_SIZE:     r_tx_size     <= i_cfg_data;
                urbf_pkg::CFG_RX_HEADROOM: r_rx_headroom <= i_cfg_data[urbf_pkg::HEAD_W-1:0];
                urbf_pkg::CFG_RX_FLOW_EN:  r_rx_flow_en  <= i_cfg_data[0];
                urbf_pkg::CFG_HALF_DUPLEX: r_half_duplex <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_put   <= '0;
            r_rx_get   <= '0;
            r_rx_count <= '0;
            r_tx_put   <= '0;
            r_tx_get   <= '0;
            r_tx_count <= '0;
            r_rts      <= 1'b0;
            r_drive    <= 1'b0;
            r_busy     <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rx_put   <= n_rx_put;
            r_rx_get   <= n_rx_get;
            r_rx_count <= n_rx_count;
            r_tx_put   <= n_tx_put;
            r_tx_get   <= n_tx_get;
            r_tx_count <= n_tx_count;
            r_rts      <= n_rts;
            r_drive    <= n_drive;
            r_busy     <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_p_status <= n_p_status;
            r_p_rvalid <= n_p_rvalid;
            r_p_svalid <= n_p_svalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status  <= r_p_status;
            r_o_rvalid  <= r_p_rvalid;
            r_o_svalid  <= r_p_svalid;
            r_o_rdata   <= r_p_rvalid ? rx_q : '0;
            r_o_sdata   <= r_p_svalid ? tx_q : '0;
            r_o_rts     <= r_rts;
            r_o_drive   <= r_drive;
            r_o_busy    <= r_busy;
            r_o_rx_fill <= r_rx_count;
            r_o_tx_fill <= r_tx_count;
        end
    end

    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_read_data    = r_o_rdata;
    assign o_read_valid   = r_o_rvalid;
    assign o_send_data    = r_o_sdata;
    assign o_send_valid   = r_o_svalid;
    assign o_rts_asserted = r_o_rts;
    assign o_tx_drive     = r_o_drive;
    assign o_tx_busy      = r_o_busy;
    assign o_rx_fill      = r_o_rx_fill;
    assign o_tx_fill      = r_o_tx_fill;

endmodule

`default_nettype wire

@@ rtl/uart_ring_buffers_flow_control_unit.sv @@
// Top level of the UART receive and transmit ring buffers with flow control.
// Each event item passes through the controller states S_IDLE and S_LOAD: in the cycle it is
// accepted the ring pointers, fills and line levels are updated and the ring RAM is read, and
// in S_LOAD, once the result register is free, the registered RAM data is placed in it. A new
// item is accepted only after that load, so no item enters while the last awaits its load,
// as set by the registered read port of the ring RAMs. The result register lets the next item
// enter while a result still waits to be taken; a second result then waits until the first
// has gone. Both rings start empty after reset and need no clearing pass.
`default_nettype none

module uart_ring_buffers_flow_control_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [urbf_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [urbf_pkg::SIZE_W-1:0]  i_cfg_data,
    urbf_in_if.sink                           i_item,
    urbf_out_if.source                        o_result
);

    urbf_pkg::t_cmd  cmd;
    urbf_pkg::t_stat stat;

    urbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    urbf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_item.operation),
        .i_data_byte    (i_item.data_byte),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_status       (o_result.status),
        .o_read_data    (o_result.read_data),
        .o_read_valid   (o_result.read_valid),
        .o_send_data    (o_result.send_data),
        .o_send_valid   (o_result.send_valid),
        .o_rts_asserted (o_result.rts_asserted),
        .o_tx_drive     (o_result.tx_drive),
        .o_tx_busy      (o_result.tx_busy),
        .o_rx_fill      (o_result.rx_fill),
        .o_tx_fill      (o_result.tx_fill)
    );

endmodule

`default_nettype wire

@@ rtl/urbf_checker.sv @@
// Port-level checks on result items of the UART ring buffer block, with their bind.
`default_nettype none

module urbf_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [urbf_pkg::STAT_W-1:0]  i_status,
    input wire logic [urbf_pkg::BYTE_W-1:0]  i_read_data,
    input wire logic                         i_read_valid,
    input wire logic [urbf_pkg::BYTE_W-1:0]  i_send_data,
    input wire logic                         i_send_valid,
    input wire logic [urbf_pkg::FILL_W-1:0]  i_rx_fill,
    input wire logic [urbf_pkg::FILL_W-1:0]  i_tx_fill
);

    localparam logic [urbf_pkg::FILL_W-1:0] RX_MAX = urbf_pkg::FILL_W'(urbf_pkg::RX_DEPTH);
    localparam logic [urbf_pkg::FILL_W-1:0] TX_MAX = urbf_pkg::FILL_W'(urbf_pkg::TX_DEPTH);

    a_data_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_read_valid || i_read_data == '0)
                         && (i_send_valid || i_send_data == '0)))
        else $error("byte field set without its valid flag");

    a_byte_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_read_valid || i_send_valid)) |->
        (i_status == urbf_pkg::ST_OK && !(i_read_valid && i_send_valid)))
        else $error("byte delivered with an error status");

    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rx_fill <= RX_MAX && i_tx_fill <= TX_MAX))
        else $error("ring fill beyond its depth");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
                                           && $stable(i_rx_fill)))
        else $error("stalled result item changed");

endmodule

bind uart_ring_buffers_flow_control_unit urbf_checker u_urbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_status     (o_result.status),
    .i_read_data  (o_result.read_data),
    .i_read_valid (o_result.read_valid),
    .i_send_data  (o_result.send_data),
    .i_send_valid (o_result.send_valid),
    .i_rx_fill    (o_result.rx_fill),
    .i_tx_fill    (o_result.tx_fill)
);

`default_nettype wire
